### sv/rne_pkg.sv
// Package for the Roman numeral encoder: microcode types, result codes and the
// value/letter pair table. Depends on nothing; every other file uses it.
package rne_pkg;

    localparam int unsigned NUMBER_W    = 16;
    localparam int unsigned REM_W       = 12;
    localparam int unsigned IDX_W       = 3;
    localparam int unsigned LETTER_W    = 7;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned LEN_W       = 5;
    localparam int unsigned COUNT_W     = 4;

    localparam logic [NUMBER_W-1:0] MAX_VALUE      = 16'd3999;
    localparam logic [LEN_W-1:0]    MAX_LENGTH_RST = 5'd16;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    localparam logic [LETTER_W-1:0] LTR_NONE = 7'h00;
    localparam logic [LETTER_W-1:0] LTR_M    = 7'h6d;
    localparam logic [LETTER_W-1:0] LTR_D    = 7'h64;
    localparam logic [LETTER_W-1:0] LTR_C    = 7'h63;
    localparam logic [LETTER_W-1:0] LTR_L    = 7'h6c;
    localparam logic [LETTER_W-1:0] LTR_X    = 7'h78;
    localparam logic [LETTER_W-1:0] LTR_V    = 7'h76;
    localparam logic [LETTER_W-1:0] LTR_I    = 7'h69;

    // Microprogram step addresses.
    typedef enum logic [1:0] {
        UPC_FULL = 2'd0,
        UPC_SUB  = 2'd1,
        UPC_SUB2 = 2'd2
    } upc_t;

    typedef enum logic [1:0] {
        COND_GE_FULL = 2'd0,
        COND_GE_SUB  = 2'd1,
        COND_ALWAYS  = 2'd2
    } cond_t;

    typedef enum logic {
        EMIT_FULL_LETTER = 1'b0,
        EMIT_SUB_LETTER  = 1'b1
    } emit_sel_t;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_FULL = 2'd1,
        OP_SUB  = 2'd2
    } op_sel_t;

    // One control word of the microprogram.
    typedef struct packed {
        cond_t     cond;
        emit_sel_t emit_sel;
        op_sel_t   op_sel;
        upc_t      jump_true;
        upc_t      jump_false;
        logic      inc_true;
        logic      inc_false;
    } ucw_t;

    // Datapath flags returned to the sequencer.
    typedef struct packed {
        logic load;
        logic met;
        logic done;
    } dp_status_t;

    typedef struct packed {
        logic [REM_W-1:0]    full;
        logic [REM_W-1:0]    sub;
        logic [LETTER_W-1:0] letter;
        logic [LETTER_W-1:0] sub_letter;
    } pair_t;

    function automatic pair_t pair_lookup(input logic [IDX_W-1:0] idx);
        pair_t p;
        unique case (idx)
            3'd0:    p = '{full: 12'd1000, sub: 12'd900, letter: LTR_M, sub_letter: LTR_C};
            3'd1:    p = '{full: 12'd500,  sub: 12'd400, letter: LTR_D, sub_letter: LTR_C};
            3'd2:    p = '{full: 12'd100,  sub: 12'd90,  letter: LTR_C, sub_letter: LTR_X};
            3'd3:    p = '{full: 12'd50,   sub: 12'd40,  letter: LTR_L, sub_letter: LTR_X};
            3'd4:    p = '{full: 12'd10,   sub: 12'd9,   letter: LTR_X, sub_letter: LTR_I};
            3'd5:    p = '{full: 12'd5,    sub: 12'd4,   letter: LTR_V, sub_letter: LTR_I};
            3'd6:    p = '{full: 12'd1,    sub: 12'd1,   letter: LTR_I, sub_letter: LTR_I};
            default: p = '{full: 12'd1,    sub: 12'd1,   letter: LTR_I, sub_letter: LTR_I};
        endcase
        return p;
    endfunction

endpackage

### sv/roman_numeral_encoder_unit.sv
// Top level of the Roman numeral encoder: length limit register, sequencer and datapath.
// Depends on rne_pkg, rne_sequencer and rne_datapath.
//
//  channel   ports                               transfer
//  --------  ----------------------------------  -----------------------------
//  command   start, busy, number                 start high while busy is low
//  result    strobe, letter, status, last        one cycle per strobe pulse
//  config    cfg_write, cfg_data                 every edge with cfg_write high
//
// A number in range runs one microprogram step per cycle, each step either emitting
// a letter or testing a pair and emitting nothing, and busy stays high for that
// run. An out-of-range number gives its error result the cycle after acceptance
// without raising busy. Each result is registered at the output in the cycle after
// its step. Reset clears the control state and sets the limit to 16.
// The receiver cannot stall, so no result ever waits.
module roman_numeral_encoder_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [rne_pkg::NUMBER_W-1:0]   number,
    input  logic                           cfg_write,
    input  logic [rne_pkg::LEN_W-1:0]      cfg_data,
    output logic                           strobe,
    output logic [rne_pkg::LETTER_W-1:0]   letter,
    output logic [rne_pkg::STATUS_W-1:0]   status,
    output logic                           last
);

    logic [rne_pkg::LEN_W-1:0] max_length_reg;
    logic [rne_pkg::LEN_W-1:0] max_length_next;
    rne_pkg::dp_status_t       flags;
    rne_pkg::ucw_t             word;
    logic                      accept;

    assign max_length_next = cfg_write ? cfg_data : max_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= rne_pkg::MAX_LENGTH_RST;
        end
        else
        begin
            max_length_reg <= max_length_next;
        end
    end

    assign accept = start && !busy;

    rne_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .busy  (busy),
        .word  (word)
    );

    rne_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .number     (number),
        .max_length (max_length_reg),
        .busy       (busy),
        .word       (word),
        .flags      (flags),
        .strobe     (strobe),
        .letter     (letter),
        .status     (status),
        .last       (last)
    );

endmodule

### sv/rne_ucode_rom.sv
// Microprogram store of the Roman numeral encoder: one control word per step.
// Depends on rne_pkg.
module rne_ucode_rom (
    input  rne_pkg::upc_t upc,
    output rne_pkg::ucw_t word
);

    // Per pair: repeat the full letter while it fits, then try the subtractive
    // pair, and move on to the next pair.
    always_comb
    begin
        unique case (upc)
            rne_pkg::UPC_FULL:
            begin
                word = '{cond: rne_pkg::COND_GE_FULL, emit_sel: rne_pkg::EMIT_FULL_LETTER,
                         op_sel: rne_pkg::OP_FULL, jump_true: rne_pkg::UPC_FULL,
                         jump_false: rne_pkg::UPC_SUB, inc_true: 1'b0, inc_false: 1'b0};
            end
            rne_pkg::UPC_SUB:
            begin
                word = '{cond: rne_pkg::COND_GE_SUB, emit_sel: rne_pkg::EMIT_SUB_LETTER,
                         op_sel: rne_pkg::OP_NONE, jump_true: rne_pkg::UPC_SUB2,
                         jump_false: rne_pkg::UPC_FULL, inc_true: 1'b0, inc_false: 1'b1};
            end
            rne_pkg::UPC_SUB2:
            begin
                word = '{cond: rne_pkg::COND_ALWAYS, emit_sel: rne_pkg::EMIT_FULL_LETTER,
                         op_sel: rne_pkg::OP_SUB, jump_true: rne_pkg::UPC_FULL,
                         jump_false: rne_pkg::UPC_FULL, inc_true: 1'b1, inc_false: 1'b1};
            end
            default:
            begin
                word = '{cond: rne_pkg::COND_ALWAYS, emit_sel: rne_pkg::EMIT_FULL_LETTER,
                         op_sel: rne_pkg::OP_NONE, jump_true: rne_pkg::UPC_FULL,
                         jump_false: rne_pkg::UPC_FULL, inc_true: 1'b0, inc_false: 1'b0};
            end
        endcase
    end

endmodule

### sv/rne_sequencer.sv
// Step counter and jump logic of the Roman numeral encoder.
// Depends on rne_pkg and rne_ucode_rom.
module rne_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  rne_pkg::dp_status_t flags,
    output logic                busy,
    output rne_pkg::ucw_t       word
);

    rne_pkg::upc_t upc_reg;
    rne_pkg::upc_t upc_next;
    logic          busy_reg;
    logic          busy_next;

    rne_ucode_rom u_rom (
        .upc  (upc_reg),
        .word (word)
    );

    always_comb
    begin
        upc_next  = upc_reg;
        busy_next = busy_reg;
        if (flags.load)
        begin
            upc_next  = rne_pkg::UPC_FULL;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            upc_next = flags.met ? word.jump_true : word.jump_false;
            if (flags.done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg  <= rne_pkg::UPC_FULL;
            busy_reg <= 1'b0;
        end
        else
        begin
            upc_reg  <= upc_next;
            busy_reg <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

### sv/rne_datapath.sv
// Datapath of the Roman numeral encoder: remainder, pair index, letter count,
// compare and subtract, and the registered result. Depends on rne_pkg.
module rne_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic [rne_pkg::NUMBER_W-1:0]        number,
    input  logic [rne_pkg::LEN_W-1:0]           max_length,
    input  logic                                busy,
    input  rne_pkg::ucw_t                       word,
    output rne_pkg::dp_status_t                 flags,
    output logic                                strobe,
    output logic [rne_pkg::LETTER_W-1:0]        letter,
    output logic [rne_pkg::STATUS_W-1:0]        status,
    output logic                                last
);

    logic [rne_pkg::REM_W-1:0]    rem_reg;
    logic [rne_pkg::REM_W-1:0]    rem_next;
    logic [rne_pkg::IDX_W-1:0]    idx_reg;
    logic [rne_pkg::IDX_W-1:0]    idx_next;
    logic [rne_pkg::COUNT_W-1:0]  count_reg;
    logic [rne_pkg::COUNT_W-1:0]  count_next;
    logic                         strobe_reg;
    logic                         strobe_next;
    logic [rne_pkg::LETTER_W-1:0] letter_reg;
    logic [rne_pkg::LETTER_W-1:0] letter_next;
    logic [rne_pkg::STATUS_W-1:0] status_reg;
    logic [rne_pkg::STATUS_W-1:0] status_next;
    logic                         last_reg;
    logic                         last_next;

    rne_pkg::pair_t               pair;
    logic                         in_range;
    logic                         met;
    logic [rne_pkg::REM_W-1:0]    operand;
    logic [rne_pkg::REM_W-1:0]    rem_after;
    logic [rne_pkg::LETTER_W-1:0] emit_char;
    logic                         overflow;
    logic                         inc;

    assign pair     = rne_pkg::pair_lookup(idx_reg);
    assign in_range = (number != '0) && (number <= rne_pkg::MAX_VALUE);

    always_comb
    begin
        case (word.cond)
            rne_pkg::COND_GE_FULL: met = (rem_reg >= pair.full);
            rne_pkg::COND_GE_SUB:  met = (rem_reg >= pair.sub);
            default:               met = 1'b1;
        endcase
        case (word.op_sel)
            rne_pkg::OP_FULL: operand = pair.full;
            rne_pkg::OP_SUB:  operand = pair.sub;
            default:          operand = '0;
        endcase
    end

    assign rem_after = rem_reg - operand;
    assign emit_char = (word.emit_sel == rne_pkg::EMIT_SUB_LETTER) ? pair.sub_letter
                                                                   : pair.letter;
    // The letter that would bring the count up to the limit becomes an overflow.
    assign overflow  = ({1'b0, count_reg} + 5'd1) >= max_length;
    assign inc       = met ? word.inc_true : word.inc_false;

    assign flags.load = accept && in_range;
    assign flags.met  = met;
    assign flags.done = met && (overflow || (rem_after == '0));

    always_comb
    begin
        rem_next    = rem_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        strobe_next = 1'b0;
        letter_next = letter_reg;
        status_next = status_reg;
        last_next   = last_reg;
        if (accept)
        begin
            rem_next   = number[rne_pkg::REM_W-1:0];
            idx_next   = '0;
            count_next = '0;
            if (!in_range)
            begin
                strobe_next = 1'b1;
                letter_next = rne_pkg::LTR_NONE;
                status_next = rne_pkg::STATUS_RANGE;
                last_next   = 1'b1;
            end
        end
        else if (busy)
        begin
            if (inc)
            begin
                idx_next = idx_reg + 3'd1;
            end
            if (met)
            begin
                strobe_next = 1'b1;
                if (overflow)
                begin
                    letter_next = rne_pkg::LTR_NONE;
                    status_next = rne_pkg::STATUS_OVERFLOW;
                    last_next   = 1'b1;
                end
                else
                begin
                    letter_next = emit_char;
                    status_next = rne_pkg::STATUS_OK;
                    last_next   = (rem_after == '0);
                    rem_next    = rem_after;
                    count_next  = count_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
            idx_reg    <= '0;
            count_reg  <= '0;
            rem_reg    <= '0;
        end
        else
        begin
            strobe_reg <= strobe_next;
            idx_reg    <= idx_next;
            count_reg  <= count_next;
            rem_reg    <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        letter_reg <= letter_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign strobe = strobe_reg;
    assign letter = letter_reg;
    assign status = status_reg;
    assign last   = last_reg;

endmodule

### tb/sv/tb.sv
// Self-checking testbench for roman_numeral_encoder_unit: a bursty command driver,
// a result monitor and a digit-wise numeral predictor. Depends on rne_pkg and the RTL.
module tb;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned DRAIN_CYCLES  = 40;
    localparam int unsigned PHASE_ITEMS   = 11;

    typedef struct packed {
        logic [rne_pkg::LETTER_W-1:0] letter;
        logic [rne_pkg::STATUS_W-1:0] status;
        logic                         last;
    } numeral_res_t;

    // A queued request is either a number to convert or a new length limit.
    typedef struct packed {
        logic                         is_limit;
        logic [rne_pkg::NUMBER_W-1:0] value;
    } numeral_req_t;

    logic                         clk;
    logic                         rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic [rne_pkg::NUMBER_W-1:0] number = '0;
    logic                         cfg_write = 1'b0;
    logic [rne_pkg::LEN_W-1:0]    cfg_data = rne_pkg::MAX_LENGTH_RST;
    logic                         strobe;
    logic [rne_pkg::LETTER_W-1:0] letter;
    logic [rne_pkg::STATUS_W-1:0] status;
    logic                         last;

    numeral_req_t request_q[$];
    numeral_res_t letters_due_q[$];

    logic [rne_pkg::LEN_W-1:0]    limit_setting;
    logic                         go;
    logic [rne_pkg::NUMBER_W-1:0] go_num;
    logic                         we;
    logic [rne_pkg::LEN_W-1:0]    wdata;
    numeral_req_t                 head;
    numeral_res_t                 want;
    int unsigned                  burst_left;
    int unsigned                  gap_left;
    int unsigned                  settle_cnt;

    int unsigned cycle_cnt;
    int unsigned mismatch_cnt;
    int unsigned numbers_sent;
    int unsigned results_seen;
    int unsigned range_cnt;
    int unsigned overflow_cnt;
    int unsigned limit_writes;

    roman_numeral_encoder_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .number    (number),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .strobe    (strobe),
        .letter    (letter),
        .status    (status),
        .last      (last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
    end

    task automatic flag_mismatch(input string what);
        begin
            mismatch_cnt++;
            $display("[cycle %0d] mismatch: %s", cycle_cnt, what);
        end
    endtask

    // Builds the numeral digit by digit and then applies the length limit:
    // the letter that would fill the buffer becomes an overflow result.
    task automatic predict_numeral(input logic [rne_pkg::NUMBER_W-1:0] num,
                                   input logic [rne_pkg::LEN_W-1:0] limit);
        logic [rne_pkg::LETTER_W-1:0] seq[$];
        logic [rne_pkg::LETTER_W-1:0] one_l;
        logic [rne_pkg::LETTER_W-1:0] five_l;
        logic [rne_pkg::LETTER_W-1:0] ten_l;
        numeral_res_t                 r;
        int unsigned                  v;
        int unsigned                  d;
        int unsigned                  k;
        int                           p;
        logic                         stopped;
        begin
            if (num == '0 || num > rne_pkg::MAX_VALUE)
            begin
                r.letter = rne_pkg::LTR_NONE;
                r.status = rne_pkg::STATUS_RANGE;
                r.last   = 1'b1;
                letters_due_q.push_back(r);
                range_cnt++;
            end
            else
            begin
                v = num;
                for (k = 0; k < v / 1000; k++)
                    seq.push_back(rne_pkg::LTR_M);
                for (p = 2; p >= 0; p--)
                begin
                    case (p)
                        2:
                        begin
                            one_l  = rne_pkg::LTR_C;
                            five_l = rne_pkg::LTR_D;
                            ten_l  = rne_pkg::LTR_M;
                            d      = (v / 100) % 10;
                        end
                        1:
                        begin
                            one_l  = rne_pkg::LTR_X;
                            five_l = rne_pkg::LTR_L;
                            ten_l  = rne_pkg::LTR_C;
                            d      = (v / 10) % 10;
                        end
                        default:
                        begin
                            one_l  = rne_pkg::LTR_I;
                            five_l = rne_pkg::LTR_V;
                            ten_l  = rne_pkg::LTR_X;
                            d      = v % 10;
                        end
                    endcase
                    if (d == 9)
                    begin
                        seq.push_back(one_l);
                        seq.push_back(ten_l);
                    end
                    else if (d == 4)
                    begin
                        seq.push_back(one_l);
                        seq.push_back(five_l);
                    end
                    else
                    begin
                        if (d >= 5)
                            seq.push_back(five_l);
                        for (k = 0; k < d % 5; k++)
                            seq.push_back(one_l);
                    end
                end
                stopped = 1'b0;
                for (k = 0; k < seq.size(); k++)
                begin
                    if (!stopped)
                    begin
                        if (k + 1 >= limit)
                        begin
                            r.letter = rne_pkg::LTR_NONE;
                            r.status = rne_pkg::STATUS_OVERFLOW;
                            r.last   = 1'b1;
                            stopped  = 1'b1;
                            overflow_cnt++;
                        end
                        else
                        begin
                            r.letter = seq[k];
                            r.status = rne_pkg::STATUS_OK;
                            r.last   = (k == seq.size() - 1);
                        end
                        letters_due_q.push_back(r);
                    end
                end
            end
        end
    endtask

    // Driver: presents numbers in bursts; a limit change waits for the block to go quiet.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start         <= 1'b0;
            number        <= '0;
            cfg_write     <= 1'b0;
            cfg_data      <= rne_pkg::MAX_LENGTH_RST;
            limit_setting = rne_pkg::MAX_LENGTH_RST;
            burst_left    = 1;
            gap_left      = 0;
            settle_cnt    = 0;
        end
        else
        begin
            go     = start;
            go_num = number;
            we     = 1'b0;
            wdata  = cfg_data;
            if (start && !busy)
            begin
                predict_numeral(number, limit_setting);
                numbers_sent++;
                go = 1'b0;
            end
            if (letters_due_q.size() == 0 && !busy && !start && !cfg_write)
                settle_cnt++;
            else
                settle_cnt = 0;
            if (!go)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (request_q.size() > 0)
                begin
                    if (request_q[0].is_limit)
                    begin
                        if (settle_cnt >= SETTLE_CYCLES)
                        begin
                            head          = request_q.pop_front();
                            we            = 1'b1;
                            wdata         = head.value[rne_pkg::LEN_W-1:0];
                            limit_setting = wdata;
                            settle_cnt    = 0;
                            limit_writes++;
                        end
                    end
                    else
                    begin
                        head   = request_q.pop_front();
                        go     = 1'b1;
                        go_num = head.value;
                        burst_left--;
                        if (burst_left == 0)
                        begin
                            burst_left = $urandom_range(1, 12);
                            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 36);
                        end
                    end
                end
            end
            start     <= go;
            number    <= go_num;
            cfg_write <= we;
            cfg_data  <= wdata;
        end
    end

    // Monitor: every strobe is one result transaction and must match the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            results_seen++;
            if (letters_due_q.size() == 0)
                flag_mismatch($sformatf("unexpected result letter=%h status=%0d last=%0d",
                                        letter, status, last));
            else
            begin
                want = letters_due_q.pop_front();
                if (letter !== want.letter)
                    flag_mismatch($sformatf("letter %h, expected %h", letter, want.letter));
                if (status !== want.status)
                    flag_mismatch($sformatf("status %0d, expected %0d", status, want.status));
                if (last !== want.last)
                    flag_mismatch($sformatf("last %0d, expected %0d", last, want.last));
            end
        end
    end

    task automatic add_number(input logic [rne_pkg::NUMBER_W-1:0] v);
        numeral_req_t q;
        begin
            q.is_limit = 1'b0;
            q.value    = v;
            request_q.push_back(q);
        end
    endtask

    task automatic add_limit(input logic [rne_pkg::LEN_W-1:0] v);
        numeral_req_t q;
        begin
            q.is_limit = 1'b1;
            q.value    = {{(rne_pkg::NUMBER_W - rne_pkg::LEN_W){1'b0}}, v};
            request_q.push_back(q);
        end
    endtask

    // Mostly legal values, a share built digit by digit to get long numerals,
    // and some out-of-range noise.
    function automatic logic [rne_pkg::NUMBER_W-1:0] pick_number();
        int unsigned sel;
        int unsigned v;
        begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
                v = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(4000, 65535);
            else if (sel < 4)
            begin
                v = $urandom_range(0, 3) * 1000 + $urandom_range(0, 9) * 100
                    + $urandom_range(0, 9) * 10 + $urandom_range(0, 9);
                if (v == 0)
                    v = 3888;
            end
            else
                v = $urandom_range(1, 3999);
            return v[rne_pkg::NUMBER_W-1:0];
        end
    endfunction

    initial
    begin
        int unsigned ph;
        int unsigned k;
        // Directed part runs at the reset limit of 16.
        add_number(16'd0);     add_number(16'd1);     add_number(16'd3999);
        add_number(16'd4000);  add_number(16'd65535); add_number(16'd32768);
        add_number(16'd3888);  add_number(16'd4);     add_number(16'd9);
        add_number(16'd40);    add_number(16'd90);    add_number(16'd400);
        add_number(16'd900);   add_number(16'd100);   add_number(16'd1994);
        add_number(16'd3);     add_number(16'd8);     add_number(16'd500);
        add_number(16'd1000);  add_number(16'd49);    add_number(16'd99);
        add_number(16'd444);   add_number(16'd999);   add_number(16'd2888);
        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:       add_limit(5'd1);
                1:       add_limit(5'd0);
                2:       add_limit(5'd31);
                3:       add_limit(5'd4);
                4:       add_limit(5'd16);
                5:       add_limit(5'd17);
                default: add_limit(5'($urandom_range(2, 15)));
            endcase
            for (k = 0; k < PHASE_ITEMS; k++)
                add_number(pick_number());
        end

        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (request_q.size() > 0 || start)
            @(posedge clk);
        while (letters_due_q.size() > 0 || busy)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d numbers into %0d results: %0d out of range, %0d overflows,",
                 numbers_sent, results_seen, range_cnt, overflow_cnt);
        $display("across %0d length limits including 0, 1, 16 and 31.", limit_writes + 1);
        if (mismatch_cnt == 0 && letters_due_q.size() == 0)
            $display("** roman_numeral_encoder_unit: PASSED **");
        else
            $display("** roman_numeral_encoder_unit: FAILED **");
        $finish;
    end

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
            @(posedge clk);
        $display("[cycle %0d] timeout with %0d results still due", cycle_cnt,
                 letters_due_q.size());
        $display("** roman_numeral_encoder_unit: FAILED **");
        $finish;
    end

endmodule

### sim.f
sv/rne_pkg.sv
sv/rne_ucode_rom.sv
sv/rne_sequencer.sv
sv/rne_datapath.sv
sv/roman_numeral_encoder_unit.sv
tb/sv/tb.sv
